[rtl/core/dmm_pkg.sv]
`default_nettype none
package dmm_pkg;

    localparam int MAX_DIM = 8;
    localparam int DIM_W   = 4;
    localparam int CNT_W   = $clog2(MAX_DIM);
    localparam int DEPTH   = 64;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int SIG_W   = 108;
    localparam int EXP_W   = 13;

    localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
    localparam logic [63:0] QUIET_BIT   = 64'h0008_0000_0000_0000;
    localparam logic [63:0] FP_ZERO     = 64'h0000_0000_0000_0000;

    typedef enum logic [1:0] {
        FUNC_LOAD_A  = 2'd0,
        FUNC_LOAD_B  = 2'd1,
        FUNC_COMPUTE = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        REG_OUT_ROWS    = 3'd0,
        REG_INNER_LEN   = 3'd1,
        REG_OUT_COLS    = 3'd2,
        REG_TRANSPOSE_A = 3'd3,
        REG_TRANSPOSE_B = 3'd4
    } reg_idx_t;

    typedef enum logic {
        FPU_MUL = 1'b0,
        FPU_ADD = 1'b1
    } fpu_op_t;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_MUL,
        FS_NORM,
        FS_ROUND
    } fpu_state_t;

    typedef enum logic [2:0] {
        CTL_IDLE,
        CTL_READ,
        CTL_MUL,
        CTL_MUL_WAIT,
        CTL_ADD,
        CTL_ADD_WAIT,
        CTL_EMIT
    } ctl_state_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] a_addr;
        logic [ADDR_W-1:0] b_addr;
        logic              fpu_start;
        fpu_op_t           fpu_op;
        logic              prod_load;
        logic              acc_load;
        logic              acc_clear;
        logic              out_load;
        logic [CNT_W-1:0]  out_row;
        logic [CNT_W-1:0]  out_col;
        logic              out_last;
    } ctl_cmd_t;

    typedef struct packed {
        logic fpu_done;
        logic out_free;
    } dp_status_t;

    // zero reads as one, anything above the maximum as the maximum
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > DIM_W'(MAX_DIM))
            r = DIM_W'(MAX_DIM);
        else
            r = v;
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/core/dmm_fpu.sv]
`default_nettype none
module dmm_fpu (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire dmm_pkg::fpu_op_t op,
    input  wire logic [63:0]    opa,
    input  wire logic [63:0]    opb,
    output logic                done,
    output logic [63:0]         result
);
    import dmm_pkg::*;

    fpu_state_t              state_reg, state_next;
    logic                    done_reg, done_next;
    logic [63:0]             res_reg, res_next;
    logic                    sign_reg, sign_next;
    logic                    zsign_reg, zsign_next;
    logic signed [EXP_W-1:0] exp_reg, exp_next;
    logic [SIG_W-1:0]        sig_reg, sig_next;
    logic [52:0]             ma_reg, ma_next, mb_reg, mb_next;
    logic [53:0]             pp_reg, pp_next;
    logic [6:0]              sh_reg, sh_next;
    logic [2:0]              step_reg, step_next;

    logic        sa, sb, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [10:0] ea_eff, eb_eff;
    logic [52:0] ma, mb;
    logic        spec;
    logic [63:0] spec_val;

    logic             a_big, s_big;
    logic [10:0]      e_big, e_sm, d;
    logic [52:0]      m_big, m_sm;
    logic [SIG_W-1:0] sig_big, sig_sm0, aligned, sum;

    logic [26:0] px, py;
    logic [6:0]  psh;

    logic [52:0] mant;
    logic        rnd_g, rnd_st, rnd_up;
    logic [53:0] mant_r;
    logic [52:0] mant_f;
    logic signed [EXP_W-1:0] e_f;

    assign sa     = opa[63];
    assign sb     = opb[63];
    assign a_nan  = (opa[62:52] == 11'h7FF) && (opa[51:0] != '0);
    assign b_nan  = (opb[62:52] == 11'h7FF) && (opb[51:0] != '0);
    assign a_inf  = (opa[62:52] == 11'h7FF) && (opa[51:0] == '0);
    assign b_inf  = (opb[62:52] == 11'h7FF) && (opb[51:0] == '0);
    assign a_zero = (opa[62:0] == '0);
    assign b_zero = (opb[62:0] == '0);
    assign ea_eff = (opa[62:52] == '0) ? 11'd1 : opa[62:52];
    assign eb_eff = (opb[62:52] == '0) ? 11'd1 : opb[62:52];
    assign ma     = {opa[62:52] != '0, opa[51:0]};
    assign mb     = {opb[62:52] != '0, opb[51:0]};

    // special operands, nan of the first operand takes priority
    always_comb
    begin
        spec     = 1'b1;
        spec_val = DEFAULT_NAN;
        if (a_nan)
            spec_val = opa | QUIET_BIT;
        else if (b_nan)
            spec_val = opb | QUIET_BIT;
        else if (op == FPU_MUL)
        begin
            if ((a_inf && b_zero) || (a_zero && b_inf))
                spec_val = DEFAULT_NAN;
            else if (a_inf || b_inf)
                spec_val = {sa ^ sb, 11'h7FF, 52'd0};
            else
                spec = 1'b0;
        end
        else
        begin
            if (a_inf && b_inf && (sa != sb))
                spec_val = DEFAULT_NAN;
            else if (a_inf)
                spec_val = opa;
            else if (b_inf)
                spec_val = opb;
            else
                spec = 1'b0;
        end
    end

    // operand alignment for addition
    always_comb
    begin
        a_big   = opa[62:0] >= opb[62:0];
        s_big   = a_big ? sa : sb;
        e_big   = a_big ? ea_eff : eb_eff;
        e_sm    = a_big ? eb_eff : ea_eff;
        m_big   = a_big ? ma : mb;
        m_sm    = a_big ? mb : ma;
        d       = e_big - e_sm;
        sig_big = {1'b0, m_big, 54'd0};
        sig_sm0 = {1'b0, m_sm, 54'd0};
        if (d > 11'd60)
            aligned = {{(SIG_W-1){1'b0}}, m_sm != '0};
        else
            aligned = (sig_sm0 >> d[5:0])
                    | SIG_W'(|(sig_sm0 & ~({SIG_W{1'b1}} << d[5:0])));
        if (sa == sb)
            sum = sig_big + aligned;
        else
            sum = sig_big - aligned;
    end

    // partial product selection, significands split 26 high and 27 low bits
    always_comb
    begin
        unique case (step_reg[1:0])
            2'd0:
            begin
                px = ma_reg[26:0];
                py = mb_reg[26:0];
                psh = 7'd2;
            end
            2'd1:
            begin
                px = ma_reg[26:0];
                py = {1'b0, mb_reg[52:27]};
                psh = 7'd29;
            end
            2'd2:
            begin
                px = {1'b0, ma_reg[52:27]};
                py = mb_reg[26:0];
                psh = 7'd29;
            end
            default:
            begin
                px = {1'b0, ma_reg[52:27]};
                py = {1'b0, mb_reg[52:27]};
                psh = 7'd56;
            end
        endcase
    end

    // round to nearest even
    always_comb
    begin
        mant   = sig_reg[106:54];
        rnd_g  = sig_reg[53];
        rnd_st = |sig_reg[52:0];
        rnd_up = rnd_g && (rnd_st || mant[0]);
        mant_r = {1'b0, mant} + 54'(rnd_up);
        if (mant_r[53])
        begin
            mant_f = mant_r[53:1];
            e_f    = exp_reg + EXP_W'(1);
        end
        else
        begin
            mant_f = mant_r[52:0];
            e_f    = exp_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        sign_next  = sign_reg;
        zsign_next = zsign_reg;
        exp_next   = exp_reg;
        sig_next   = sig_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        pp_next    = pp_reg;
        sh_next    = sh_reg;
        step_next  = step_reg;
        unique case (state_reg)
            FS_IDLE:
            begin
                if (start)
                begin
                    if (spec)
                    begin
                        res_next  = spec_val;
                        done_next = 1'b1;
                    end
                    else if (op == FPU_MUL)
                    begin
                        sign_next  = sa ^ sb;
                        zsign_next = sa ^ sb;
                        exp_next   = $signed({2'b00, ea_eff}) + $signed({2'b00, eb_eff})
                                   - EXP_W'(1023);
                        sig_next   = '0;
                        ma_next    = ma;
                        mb_next    = mb;
                        pp_next    = '0;
                        sh_next    = '0;
                        step_next  = '0;
                        state_next = FS_MUL;
                    end
                    else
                    begin
                        sign_next  = s_big;
                        zsign_next = sa & sb;
                        exp_next   = $signed({2'b00, e_big});
                        sig_next   = sum;
                        state_next = FS_NORM;
                    end
                end
            end
            FS_MUL:
            begin
                sig_next  = sig_reg + (SIG_W'(pp_reg) << sh_reg);
                pp_next   = 54'(px) * 54'(py);
                sh_next   = psh;
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd4)
                    state_next = FS_NORM;
            end
            FS_NORM:
            begin
                if (sig_reg == '0)
                    state_next = FS_ROUND;
                else if (sig_reg[SIG_W-1])
                begin
                    sig_next = {1'b0, sig_reg[SIG_W-1:2], sig_reg[1] | sig_reg[0]};
                    exp_next = exp_reg + EXP_W'(1);
                end
                else if (exp_reg < EXP_W'(-120))
                begin
                    sig_next = {{(SIG_W-1){1'b0}}, 1'b1};
                    exp_next = EXP_W'(1);
                end
                else if (exp_reg < EXP_W'(1))
                begin
                    sig_next = {1'b0, sig_reg[SIG_W-1:2], sig_reg[1] | sig_reg[0]};
                    exp_next = exp_reg + EXP_W'(1);
                end
                else if (!sig_reg[106] && (exp_reg > EXP_W'(1)))
                begin
                    sig_next = {sig_reg[SIG_W-2:0], 1'b0};
                    exp_next = exp_reg - EXP_W'(1);
                end
                else
                    state_next = FS_ROUND;
            end
            FS_ROUND:
            begin
                if (sig_reg == '0)
                    res_next = {zsign_reg, 63'd0};
                else if (e_f >= EXP_W'(2047))
                    res_next = {sign_reg, 11'h7FF, 52'd0};
                else
                    res_next = {sign_reg, mant_f[52] ? e_f[10:0] : 11'd0, mant_f[51:0]};
                done_next  = 1'b1;
                state_next = FS_IDLE;
            end
            default:
                state_next = FS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg   <= res_next;
        sign_reg  <= sign_next;
        zsign_reg <= zsign_next;
        exp_reg   <= exp_next;
        sig_reg   <= sig_next;
        ma_reg    <= ma_next;
        mb_reg    <= mb_next;
        pp_reg    <= pp_next;
        sh_reg    <= sh_next;
        step_reg  <= step_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule
`default_nettype wire

[rtl/core/dmm_dpath.sv]
`default_nettype none
module dmm_dpath (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        load_a,
    input  wire logic                        load_b,
    input  wire logic [dmm_pkg::ADDR_W-1:0]  load_index,
    input  wire logic [63:0]                 load_value,
    input  wire dmm_pkg::ctl_cmd_t           cmd,
    output dmm_pkg::dp_status_t              status,
    input  wire logic                        out_stall,
    output logic                             out_valid,
    output logic [63:0]                      result_value,
    output logic [dmm_pkg::CNT_W-1:0]        result_row,
    output logic [dmm_pkg::CNT_W-1:0]        result_col,
    output logic                             result_last
);
    import dmm_pkg::*;

    logic [63:0] a_mem [DEPTH];
    logic [63:0] b_mem [DEPTH];
    logic [63:0] a_rd_reg, b_rd_reg;
    logic [63:0] acc_reg, prod_reg;
    logic [63:0] fpu_a, fpu_b, fpu_res;
    logic        fpu_done;

    logic             out_valid_reg, out_valid_next;
    logic [63:0]      val_reg;
    logic [CNT_W-1:0] row_reg, col_reg;
    logic             last_reg;
    logic             out_free;

    always_ff @(posedge clk)
    begin
        if (load_a)
            a_mem[load_index] <= load_value;
        if (cmd.rd_en)
            a_rd_reg <= a_mem[cmd.a_addr];
    end

    always_ff @(posedge clk)
    begin
        if (load_b)
            b_mem[load_index] <= load_value;
        if (cmd.rd_en)
            b_rd_reg <= b_mem[cmd.b_addr];
    end

    assign fpu_a = (cmd.fpu_op == FPU_MUL) ? a_rd_reg : acc_reg;
    assign fpu_b = (cmd.fpu_op == FPU_MUL) ? b_rd_reg : prod_reg;

    dmm_fpu u_fpu (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.fpu_start),
        .op     (cmd.fpu_op),
        .opa    (fpu_a),
        .opb    (fpu_b),
        .done   (fpu_done),
        .result (fpu_res)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.prod_load)
            prod_reg <= fpu_res;
        if (cmd.acc_clear)
            acc_reg <= FP_ZERO;
        else if (cmd.acc_load)
            acc_reg <= fpu_res;
    end

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            val_reg  <= acc_reg;
            row_reg  <= cmd.out_row;
            col_reg  <= cmd.out_col;
            last_reg <= cmd.out_last;
        end
    end

    assign status.fpu_done = fpu_done;
    assign status.out_free = out_free;
    assign out_valid    = out_valid_reg;
    assign result_value = val_reg;
    assign result_row   = row_reg;
    assign result_col   = col_reg;
    assign result_last  = last_reg;

endmodule
`default_nettype wire

[rtl/core/dmm_ctrl.sv]
`default_nettype none
module dmm_ctrl (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [dmm_pkg::DIM_W-1:0]  dim_m,
    input  wire logic [dmm_pkg::DIM_W-1:0]  dim_k,
    input  wire logic [dmm_pkg::DIM_W-1:0]  dim_n,
    input  wire logic                       trans_a,
    input  wire logic                       trans_b,
    input  wire dmm_pkg::dp_status_t        status,
    output dmm_pkg::ctl_cmd_t               cmd,
    output logic                            busy
);
    import dmm_pkg::*;

    localparam int PROD_W = CNT_W + DIM_W + 1;

    ctl_state_t       state_reg, state_next;
    logic [CNT_W-1:0] j_reg, j_next, r_reg, r_next, t_reg, t_next;
    logic [CNT_W-1:0] m_last, k_last, n_last;
    logic [PROD_W-1:0] ai, bi;

    assign m_last = CNT_W'(dim_m - DIM_W'(1));
    assign k_last = CNT_W'(dim_k - DIM_W'(1));
    assign n_last = CNT_W'(dim_n - DIM_W'(1));

    // column-major storage index of opA(r,t) and opB(t,j)
    assign ai = trans_a ? PROD_W'(PROD_W'(r_reg) * PROD_W'(dim_k) + PROD_W'(t_reg))
                        : PROD_W'(PROD_W'(t_reg) * PROD_W'(dim_m) + PROD_W'(r_reg));
    assign bi = trans_b ? PROD_W'(PROD_W'(t_reg) * PROD_W'(dim_n) + PROD_W'(j_reg))
                        : PROD_W'(PROD_W'(j_reg) * PROD_W'(dim_k) + PROD_W'(t_reg));

    always_comb
    begin
        state_next    = state_reg;
        j_next        = j_reg;
        r_next        = r_reg;
        t_next        = t_reg;
        cmd           = '0;
        cmd.fpu_op    = FPU_MUL;
        cmd.a_addr    = ai[ADDR_W-1:0];
        cmd.b_addr    = bi[ADDR_W-1:0];
        cmd.out_row   = r_reg;
        cmd.out_col   = j_reg;
        cmd.out_last  = (r_reg == m_last) && (j_reg == n_last);
        unique case (state_reg)
            CTL_IDLE:
            begin
                if (start)
                begin
                    j_next        = '0;
                    r_next        = '0;
                    t_next        = '0;
                    cmd.acc_clear = 1'b1;
                    state_next    = CTL_READ;
                end
            end
            CTL_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = CTL_MUL;
            end
            CTL_MUL:
            begin
                cmd.fpu_start = 1'b1;
                state_next    = CTL_MUL_WAIT;
            end
            CTL_MUL_WAIT:
            begin
                if (status.fpu_done)
                begin
                    cmd.prod_load = 1'b1;
                    state_next    = CTL_ADD;
                end
            end
            CTL_ADD:
            begin
                cmd.fpu_op    = FPU_ADD;
                cmd.fpu_start = 1'b1;
                state_next    = CTL_ADD_WAIT;
            end
            CTL_ADD_WAIT:
            begin
                cmd.fpu_op = FPU_ADD;
                if (status.fpu_done)
                begin
                    cmd.acc_load = 1'b1;
                    if (t_reg == k_last)
                        state_next = CTL_EMIT;
                    else
                    begin
                        t_next     = t_reg + CNT_W'(1);
                        state_next = CTL_READ;
                    end
                end
            end
            CTL_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.acc_clear = 1'b1;
                    t_next        = '0;
                    state_next    = CTL_READ;
                    if (r_reg == m_last)
                    begin
                        r_next = '0;
                        if (j_reg == n_last)
                            state_next = CTL_IDLE;
                        else
                            j_next = j_reg + CNT_W'(1);
                    end
                    else
                        r_next = r_reg + CNT_W'(1);
                end
            end
            default:
                state_next = CTL_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CTL_IDLE;
            j_reg     <= '0;
            r_reg     <= '0;
            t_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            j_reg     <= j_next;
            r_reg     <= r_next;
            t_reg     <= t_next;
        end
    end

    assign busy = (state_reg != CTL_IDLE);

endmodule
`default_nettype wire

[rtl/core/dense_matrix_multiply_top.sv]
`default_nettype none
// double-precision matrix multiply engine, X = op(A) * op(B), all column-major
//
// input channel (in_valid / in_stall): func selects load A, load B or compute.
// a load transfer writes elem_value into the A or B store at elem_index;
// loads stream at one per cycle while the engine is idle.
// a compute transfer emits every element of X on the output channel
// (out_valid / out_stall), column outer and row inner, result_last on the end.
// in_stall stays high for the whole compute walk.
// per product term: a registered store read, then the multiply (four 27x27
// partial products through one multiplier) plus normalize and round, then
// the add plus normalize and round; normalize is one bit per cycle in the
// shared float unit and runs longer after heavy cancellation or with
// subnormals. special operands skip multiply, normalize and round and finish
// straight from idle. one element costs k terms plus the output register load.
// a stalled result holds in the output register and the walk waits there.
// reset clears control and restores the dimension registers to 8 and the
// transpose flags to 0; the stores are not cleared and must be written first.
// config (apb, pready always high): write only while idle, not enforced here.
module dense_matrix_multiply_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  func,
    input  wire logic [5:0]  elem_index,
    input  wire logic [63:0] elem_value,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      result_value,
    output logic [2:0]       result_row,
    output logic [2:0]       result_col,
    output logic             result_last
);
    import dmm_pkg::*;

    logic [DIM_W-1:0] out_rows_reg, inner_len_reg, out_cols_reg;
    logic             transpose_a_reg, transpose_b_reg;
    logic             cfg_wr;
    reg_idx_t         cfg_idx;

    logic       in_xfer;
    logic       busy;
    ctl_cmd_t   cmd;
    dp_status_t status;

    // register write at the access phase, index from the word address
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_rows_reg    <= DIM_W'(MAX_DIM);
            inner_len_reg   <= DIM_W'(MAX_DIM);
            out_cols_reg    <= DIM_W'(MAX_DIM);
            transpose_a_reg <= 1'b0;
            transpose_b_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_OUT_ROWS:    out_rows_reg    <= pwdata[DIM_W-1:0];
                REG_INNER_LEN:   inner_len_reg   <= pwdata[DIM_W-1:0];
                REG_OUT_COLS:    out_cols_reg    <= pwdata[DIM_W-1:0];
                REG_TRANSPOSE_A: transpose_a_reg <= pwdata[0];
                REG_TRANSPOSE_B: transpose_b_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_OUT_ROWS:    prdata = 32'(out_rows_reg);
            REG_INNER_LEN:   prdata = 32'(inner_len_reg);
            REG_OUT_COLS:    prdata = 32'(out_cols_reg);
            REG_TRANSPOSE_A: prdata = 32'(transpose_a_reg);
            REG_TRANSPOSE_B: prdata = 32'(transpose_b_reg);
            default:         prdata = '0;
        endcase
    end

    // input transfers are taken only while the walk is idle
    assign in_stall = busy;
    assign in_xfer  = in_valid && !in_stall;

    dmm_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (in_xfer && (func == FUNC_COMPUTE)),
        .dim_m   (eff_dim(out_rows_reg)),
        .dim_k   (eff_dim(inner_len_reg)),
        .dim_n   (eff_dim(out_cols_reg)),
        .trans_a (transpose_a_reg),
        .trans_b (transpose_b_reg),
        .status  (status),
        .cmd     (cmd),
        .busy    (busy)
    );

    dmm_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .load_a       (in_xfer && (func == FUNC_LOAD_A)),
        .load_b       (in_xfer && (func == FUNC_LOAD_B)),
        .load_index   (elem_index),
        .load_value   (elem_value),
        .cmd          (cmd),
        .status       (status),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .result_value (result_value),
        .result_row   (result_row),
        .result_col   (result_col),
        .result_last  (result_last)
    );

    // a compute transfer closes the input side on the next cycle
    a_compute_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (func == FUNC_COMPUTE) |=> in_stall)
        else $error("input not stalled after compute transfer");

    // a result is never written over one that is still waiting
    a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("output register overwritten");

    // the float unit is only started during a walk
    a_fpu_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fpu_start |-> busy)
        else $error("float unit started while idle");

endmodule
`default_nettype wire
